/* sv/srtf_pkg.sv */
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and constants for the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int TASK_ID_BITS = 8;
  localparam int TIME_BITS    = 32;
  localparam int COUNT_BITS   = 5;

  typedef logic [TASK_ID_BITS-1:0] task_id_t;
  typedef logic [TIME_BITS-1:0]    tval_t;
  typedef logic [COUNT_BITS-1:0]   count_t;

  // event kinds carried in the mode field
  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_DEPART = 1'b1;

  typedef struct packed {
    logic     mode;
    task_id_t task_id;
    tval_t    task_remaining;
    tval_t    running_remaining;
  } evt_req_t;

  typedef struct packed {
    logic     switched;
    task_id_t switch_task;
    logic     running_valid;
    task_id_t running_task;
    count_t   ready_count;
    logic     dropped;
  } res_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_SCHED,
    ST_REQUEUE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    Q_NONE,
    Q_INSERT,
    Q_REMOVE_ID,
    Q_REMOVE_HEAD
  } queue_op_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic do_event;
    logic dispatch;
    logic requeue;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head_valid;
    logic cpu_busy;
    logic preempt;
    logic out_free;
  } dp_status_t;

endpackage

/* sv/srtf_queue.sv */
// ----------------------------------------------------------------------------
// srtf_queue
// Sorted shift chain of (key, task) entries: ordered insert, remove by id,
// remove head.
// ----------------------------------------------------------------------------
module srtf_queue import srtf_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int FILL_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  queue_op_t         op,
  input  task_id_t          ins_task,
  input  tval_t             ins_key,
  input  task_id_t          rm_task,
  output logic [FILL_W-1:0] fill,
  output logic              full,
  output task_id_t          head_task,
  output tval_t             head_key
);

  tval_t    key_q  [DEPTH];
  task_id_t task_q [DEPTH];

  logic [DEPTH-1:0] gt;      // valid entry with key above the new key
  logic [DEPTH-1:0] match;   // valid entry with the id being removed
  logic [DEPTH-1:0] rm_at;   // entry at or behind the first match
  logic             found;

  assign full      = (fill == FILL_W'(DEPTH));
  assign head_task = task_q[0];
  assign head_key  = key_q[0];
  assign found     = |match;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i]    = (FILL_W'(i) < fill) && (key_q[i] > ins_key);
      match[i] = (FILL_W'(i) < fill) && (task_q[i] == rm_task);
      rm_at[i] = |(match & ~({DEPTH{1'b1}} << (i + 1)));
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic     lo_gt;
    tval_t    lo_key;
    task_id_t lo_task;
    tval_t    hi_key;
    task_id_t hi_task;

    if (g == 0) begin : g_first
      assign lo_gt   = 1'b0;
      assign lo_key  = key_q[g];
      assign lo_task = task_q[g];
    end else begin : g_mid
      assign lo_gt   = gt[g-1];
      assign lo_key  = key_q[g-1];
      assign lo_task = task_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign hi_key  = key_q[g];
      assign hi_task = task_q[g];
    end else begin : g_inner
      assign hi_key  = key_q[g+1];
      assign hi_task = task_q[g+1];
    end

    always_ff @(posedge clk) begin
      case (op)
        Q_INSERT: begin
          if (!full) begin
            if (lo_gt) begin
              key_q[g]  <= lo_key;
              task_q[g] <= lo_task;
            end else if (gt[g] || (FILL_W'(g) == fill)) begin
              key_q[g]  <= ins_key;
              task_q[g] <= ins_task;
            end
          end
        end
        Q_REMOVE_ID: begin
          if (rm_at[g]) begin
            key_q[g]  <= hi_key;
            task_q[g] <= hi_task;
          end
        end
        Q_REMOVE_HEAD: begin
          if (fill != '0) begin
            key_q[g]  <= hi_key;
            task_q[g] <= hi_task;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      case (op)
        Q_INSERT: begin
          if (!full) fill <= fill + 1'b1;
        end
        Q_REMOVE_ID: begin
          if (found) fill <= fill - 1'b1;
        end
        Q_REMOVE_HEAD: begin
          if (fill != '0) fill <= fill - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("queue fill beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (op == Q_INSERT && !full) |=> (fill == $past(fill) + 1'b1))
    else $error("insert did not grow the queue");

endmodule

/* sv/srtf_ctrl.sv */
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: event, schedule, optional re-queue of a preempted task, result.
// ----------------------------------------------------------------------------
module srtf_ctrl import srtf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       evt_valid,
  output logic       evt_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    evt_stall  = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (evt_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EVENT;
        end
      end
      ST_EVENT: begin
        cmd.do_event = 1'b1;
        state_next   = ST_SCHED;
      end
      ST_SCHED: begin
        state_next = ST_DONE;
        if (status.head_valid && (!status.cpu_busy || status.preempt)) begin
          cmd.dispatch = 1'b1;
          if (status.cpu_busy) state_next = ST_REQUEUE;
        end
      end
      ST_REQUEUE: begin
        cmd.requeue = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_requeue_after_sched: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REQUEUE) |-> ($past(state) == ST_SCHED))
    else $error("re-queue without a preempting dispatch");

endmodule

/* sv/srtf_dp.sv */
// ----------------------------------------------------------------------------
// srtf_dp
// Datapath: request register, running-task state, ready queue, result register.
// ----------------------------------------------------------------------------
module srtf_dp import srtf_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  evt_req_t   evt_req,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       res_valid,
  input  logic       res_stall,
  output res_req_t   res_req
);

  localparam int FILL_W = $clog2(DEPTH + 1);

  evt_req_t          req_r;
  logic              cpu_busy;
  task_id_t          cpu_task;
  task_id_t          prev_task;
  logic              switched;
  task_id_t          switch_to;
  logic              dropped;

  queue_op_t         q_op;
  task_id_t          q_ins_task;
  tval_t             q_ins_key;
  logic [FILL_W-1:0] q_fill;
  logic              q_full;
  task_id_t          q_head_task;
  tval_t             q_head_key;

  always_comb begin
    q_op = Q_NONE;
    if (cmd.do_event) begin
      q_op = (req_r.mode == MODE_ARRIVE) ? Q_INSERT : Q_REMOVE_ID;
    end else if (cmd.dispatch) begin
      q_op = Q_REMOVE_HEAD;
    end else if (cmd.requeue) begin
      q_op = Q_INSERT;
    end
  end

  assign q_ins_task = cmd.requeue ? prev_task : req_r.task_id;
  assign q_ins_key  = cmd.requeue ? req_r.running_remaining : req_r.task_remaining;

  srtf_queue #(
    .DEPTH  (DEPTH),
    .FILL_W (FILL_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .op        (q_op),
    .ins_task  (q_ins_task),
    .ins_key   (q_ins_key),
    .rm_task   (req_r.task_id),
    .fill      (q_fill),
    .full      (q_full),
    .head_task (q_head_task),
    .head_key  (q_head_key)
  );

  assign status.head_valid = (q_fill != '0);
  assign status.cpu_busy   = cpu_busy;
  assign status.preempt    = (q_head_key < req_r.running_remaining);
  assign status.out_free   = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_in) req_r <= evt_req;
    if (cmd.dispatch) prev_task <= cpu_task;
    if (cmd.load_out) begin
      res_req.switched      <= switched;
      res_req.switch_task   <= switch_to;
      res_req.running_valid <= cpu_busy;
      res_req.running_task  <= cpu_busy ? cpu_task : '0;
      res_req.ready_count   <= COUNT_BITS'(q_fill);
      res_req.dropped       <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_busy  <= 1'b0;
      cpu_task  <= '0;
      switched  <= 1'b0;
      switch_to <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        switched  <= 1'b0;
        switch_to <= '0;
        dropped   <= 1'b0;
      end
      if (cmd.do_event) begin
        if (req_r.mode == MODE_DEPART && cpu_busy && cpu_task == req_r.task_id) begin
          cpu_busy <= 1'b0;
        end
        if (req_r.mode == MODE_ARRIVE && q_full) dropped <= 1'b1;
      end
      if (cmd.dispatch) begin
        cpu_busy  <= 1'b1;
        cpu_task  <= q_head_task;
        switched  <= 1'b1;
        switch_to <= q_head_task;
      end
      if (cmd.load_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_dispatch_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.dispatch |=> (cpu_busy && switched))
    else $error("dispatch left the CPU idle");

endmodule

/* sv/shortest_remaining_time_scheduler.sv */
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler
// Preemptive shortest-remaining-time-first dispatcher with a sorted ready queue.
// ----------------------------------------------------------------------------
//  channel | signals                       | carries
//  --------+-------------------------------+-----------------------------------
//  evt     | evt_valid, evt_stall, evt_req | arrival / departure request
//  res     | res_valid, res_stall, res_req | dispatch decision and queue status
//
//  Once a request is taken the sequencer walks it through event, schedule,
//  re-queue of the preempted task (only when it preempts the running task)
//  and result, and the result then sits in the output register. The
//  single-ported sorted shift chain (one insert or remove per cycle) keeps
//  these steps apart. The next request is taken once the result sits in
//  the output register; a stalled result holds the sequencer in its last
//  step.
//  Reset (rst, synchronous) empties the queue and idles the CPU; no clearing
//  pass is needed, as only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler import srtf_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     evt_valid,
  output logic     evt_stall,
  input  evt_req_t evt_req,
  output logic     res_valid,
  input  logic     res_stall,
  output res_req_t res_req
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer: walks each request through its steps.
  srtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: queue, running task and result register.
  srtf_dp #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .evt_req   (evt_req),
    .cmd       (cmd),
    .status    (status),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_req   (res_req)
  );

endmodule

/* dv/shortest_remaining_time_scheduler_test.sv */
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_test
// Self-checking bench for the SRTF dispatcher. A short list of hand-picked
// arrival/departure requests comes first, then random traffic. Every result
// is checked against its typed row, else a behavioral queue and CPU model.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_test;
  import srtf_pkg::*;

  localparam int QDEPTH     = 16;
  localparam int RAND_ITEMS = 2000;
  localparam int CALM_ITEMS = 300;  // tail of the run with no idling at all
  localparam int SQUEEZE_AT = 800;  // request count that triggers the long hold
  localparam int SQUEEZE_N  = 300;  // length of the long receiver hold, cycles

  // one row of the directed list; want is used only when typed is set
  typedef struct {
    evt_req_t ev;
    bit       typed;
    res_req_t want;
  } probe_row_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     evt_valid;
  logic     evt_stall;
  evt_req_t evt_req;
  logic     res_valid;
  logic     res_stall;
  res_req_t res_req;

  // bench-side model of the block: sorted ready queue plus the running task
  tval_t    rq_key [QDEPTH];
  task_id_t rq_task[QDEPTH];
  int       rq_fill = 0;
  bit       cpu_on  = 1'b0;
  task_id_t cpu_id  = '0;

  res_req_t   pending[$];  // dispatch decisions still owed by the block
  probe_row_t probes[$];
  int         errors = 0;
  int         n_sent = 0;
  bit         calm   = 1'b0;

  shortest_remaining_time_scheduler #(
    .QUEUE_DEPTH(QDEPTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt_req   (evt_req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_req   (res_req)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop, set well beyond the slowest legal run: roughly 2k requests,
  // each with its busy steps, gap and result stall, plus the long hold.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Ready queue model
  // --------------------------------------------------------------------------

  // Insert behind every entry whose key is not greater (ties keep arrival
  // order). Returns 0 when the queue is already full.
  function automatic bit ready_insert(task_id_t id, tval_t key);
    int i;
    if (rq_fill >= QDEPTH) return 1'b0;
    i = rq_fill;
    while (i > 0 && rq_key[i-1] > key) begin
      rq_key[i]  = rq_key[i-1];
      rq_task[i] = rq_task[i-1];
      i--;
    end
    rq_key[i]  = key;
    rq_task[i] = id;
    rq_fill++;
    return 1'b1;
  endfunction

  function automatic void ready_remove_at(int pos);
    if (pos >= rq_fill) return;
    for (int j = pos; j + 1 < rq_fill; j++) begin
      rq_key[j]  = rq_key[j+1];
      rq_task[j] = rq_task[j+1];
    end
    rq_fill--;
  endfunction

  // Apply one request to the model and return the decision it must produce.
  function automatic res_req_t schedule_event(evt_req_t e);
    res_req_t r;
    int       hit;
    task_id_t head_id;
    tval_t    head_key;
    r   = '0;
    hit = -1;
    if (e.mode == MODE_ARRIVE) begin
      // full queue loses the arrival but scheduling still runs
      r.dropped = !ready_insert(e.task_id, e.task_remaining);
    end else begin
      if (cpu_on && cpu_id == e.task_id) cpu_on = 1'b0;
      // only the first queued entry with this id goes
      for (int i = 0; i < rq_fill; i++) begin
        if (hit < 0 && rq_task[i] == e.task_id) hit = i;
      end
      if (hit >= 0) ready_remove_at(hit);
    end

    if (rq_fill > 0) begin
      head_id  = rq_task[0];
      head_key = rq_key[0];
      if (!cpu_on) begin
        ready_remove_at(0);
        cpu_on        = 1'b1;
        cpu_id        = head_id;
        r.switched    = 1'b1;
        r.switch_task = head_id;
      end else if (head_key < e.running_remaining) begin
        // head leaves before the preempted task goes back, so no drop here
        ready_remove_at(0);
        void'(ready_insert(cpu_id, e.running_remaining));
        cpu_id        = head_id;
        r.switched    = 1'b1;
        r.switch_task = head_id;
      end
    end

    r.running_valid = cpu_on;
    r.running_task  = cpu_on ? cpu_id : '0;
    r.ready_count   = count_t'(rq_fill);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void flag(string field, logic [7:0] want, logic [7:0] got);
    $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
    errors++;
  endfunction

  function automatic void check_result(res_req_t got);
    res_req_t want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result, expected none got %p", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.switched !== want.switched)
      flag("switched", 8'(want.switched), 8'(got.switched));
    if (got.switch_task !== want.switch_task)
      flag("switch_task", want.switch_task, got.switch_task);
    if (got.running_valid !== want.running_valid)
      flag("running_valid", 8'(want.running_valid), 8'(got.running_valid));
    if (got.running_task !== want.running_task)
      flag("running_task", want.running_task, got.running_task);
    if (got.ready_count !== want.ready_count)
      flag("ready_count", 8'(want.ready_count), 8'(got.ready_count));
    if (got.dropped !== want.dropped)
      flag("dropped", 8'(want.dropped), 8'(got.dropped));
  endfunction

  // Result side: sample at the edge, then pick the stall for the next cycle.
  // Stall and run stretches come in random bursts; once, after enough
  // traffic, a long hold lets the block back up into its request input.
  initial begin
    int burst_left;
    bit burst_stall;
    bit squeezed;
    burst_left  = 0;
    burst_stall = 1'b0;
    squeezed    = 1'b0;
    res_stall   = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) check_result(res_req);
      if (burst_left == 0) begin
        if (!squeezed && n_sent >= SQUEEZE_AT) begin
          squeezed    = 1'b1;
          burst_stall = 1'b1;
          burst_left  = SQUEEZE_N;
        end else if (calm) begin
          burst_stall = 1'b0;
          burst_left  = 1;
        end else begin
          burst_stall = ($urandom_range(2) == 0);
          burst_left  = burst_stall ? $urandom_range(1, 10) : $urandom_range(1, 40);
        end
      end
      burst_left--;
      res_stall <= burst_stall;
    end
  end

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request and hold it until taken. The model is updated at the
  // accepting edge, which keeps it in step with the block's own order.
  task automatic offer(evt_req_t ev, bit typed, res_req_t want);
    res_req_t guess;
    evt_req   <= ev;
    evt_valid <= 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    guess = schedule_event(ev);
    pending.push_back(typed ? want : guess);
    n_sent++;
    if (!calm && $urandom_range(3) == 0) begin
      evt_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic void add_probe(evt_req_t ev, bit typed = 1'b0,
                                    res_req_t want = '0);
    probe_row_t row;
    row.ev    = ev;
    row.typed = typed;
    row.want  = want;
    probes.push_back(row);
  endfunction

  initial begin
    evt_req_t ev;
    int       arrive_pct;
    int       pick;
    int       wait_n;
    rst       = 1'b1;
    evt_valid = 1'b0;
    evt_req   = '0;

    // Directed list. Result fields: switched, switch_task, running_valid,
    // running_task, ready_count, dropped.
    // departure on an empty scheduler: nothing happens
    add_probe(evt_req_t'{MODE_DEPART, 8'h05, 32'h0, 32'h0}, 1'b1,
              res_req_t'{1'b0, 8'h00, 1'b0, 8'h00, 5'd0, 1'b0});
    // first arrival with the largest time goes straight to the idle CPU
    add_probe(evt_req_t'{MODE_ARRIVE, 8'h00, 32'hFFFF_FFFF, 32'h0}, 1'b1,
              res_req_t'{1'b1, 8'h00, 1'b1, 8'h00, 5'd0, 1'b0});
    // zero time against the largest running time: preempts, task 0 re-queued
    add_probe(evt_req_t'{MODE_ARRIVE, 8'hFF, 32'h0, 32'hFFFF_FFFF}, 1'b1,
              res_req_t'{1'b1, 8'hFF, 1'b1, 8'hFF, 5'd1, 1'b0});
    // equal remaining time does not preempt
    add_probe(evt_req_t'{MODE_ARRIVE, 8'h07, 32'd100, 32'd100}, 1'b1,
              res_req_t'{1'b0, 8'h00, 1'b1, 8'hFF, 5'd2, 1'b0});
    // tie on key: queued behind task 7
    add_probe(evt_req_t'{MODE_ARRIVE, 8'h08, 32'd100, 32'd50});
    // running task leaves: head (task 7, first of the tie) dispatched
    add_probe(evt_req_t'{MODE_DEPART, 8'hFF, 32'h0, 32'h0}, 1'b1,
              res_req_t'{1'b1, 8'h07, 1'b1, 8'h07, 5'd2, 1'b0});
    // duplicate id: task 7 both running and queued
    add_probe(evt_req_t'{MODE_ARRIVE, 8'h07, 32'd5, 32'd5});
    // departure idles the CPU and removes the queued copy too
    add_probe(evt_req_t'{MODE_DEPART, 8'h07, 32'd80, 32'd80});
    // unknown id leaves: no change
    add_probe(evt_req_t'{MODE_DEPART, 8'hC8, 32'h0, 32'h0});
    // fill the queue to the brim without preempting
    for (int i = 0; i < 15; i++)
      add_probe(evt_req_t'{MODE_ARRIVE, 8'(8'h20 + i), 32'(32'h1000 + i), 32'h0});
    // arrival on a full queue is dropped, yet the preemption still happens
    add_probe(evt_req_t'{MODE_ARRIVE, 8'hAA, 32'h0, 32'hFFFF_FFFF}, 1'b1,
              res_req_t'{1'b1, 8'h20, 1'b1, 8'h20, 5'd16, 1'b1});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[k]) offer(probes[k].ev, probes[k].typed, probes[k].want);

    // Random traffic in phases that drain, balance and flood the queue. Ids
    // come mostly from a small pool so departures hit queued and running
    // tasks; running times often sit right at the head's key.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= RAND_ITEMS - CALM_ITEMS);
      case ((n / 250) % 3)
        0:       arrive_pct = 30;
        1:       arrive_pct = 55;
        default: arrive_pct = 85;
      endcase
      ev = '0;
      ev.mode = ($urandom_range(99) < arrive_pct) ? MODE_ARRIVE : MODE_DEPART;
      if (ev.mode == MODE_ARRIVE) begin
        ev.task_id = ($urandom_range(9) < 7) ? task_id_t'($urandom_range(11))
                                             : task_id_t'($urandom_range(255));
      end else begin
        pick = $urandom_range(9);
        if (pick < 5 && cpu_on)
          ev.task_id = cpu_id;
        else if (pick < 8 && rq_fill > 0)
          ev.task_id = rq_task[$urandom_range(rq_fill - 1)];
        else
          ev.task_id = task_id_t'($urandom_range(255));
      end
      case ($urandom_range(3))
        0:       ev.task_remaining = $urandom_range(15);
        1:       ev.task_remaining = $urandom;
        2:       ev.task_remaining = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        default: ev.task_remaining = $urandom_range(1000);
      endcase
      // head key minus one, equal, or plus one: just-no, tie and just-yes
      if (rq_fill > 0 && $urandom_range(9) < 4)
        ev.running_remaining = rq_key[0] + $urandom_range(2) - 1;
      else begin
        case ($urandom_range(3))
          0:       ev.running_remaining = $urandom_range(15);
          1:       ev.running_remaining = $urandom;
          2:       ev.running_remaining = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
          default: ev.running_remaining = $urandom_range(1000);
        endcase
      end
      offer(ev, 1'b0, '0);
    end
    evt_valid <= 1'b0;

    // drain: every owed result must show up, then a few quiet cycles
    wait_n = 0;
    while (pending.size() > 0 && wait_n < 20000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (20) @(posedge clk);
    if (pending.size() > 0) begin
      $display("%0t: results missing, expected %0d more got 0", $time, pending.size());
      errors += pending.size();
    end
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
